### rtl/hnm_pkg.sv
// Package for the Hamming nearest-match block: command codes and field widths.
// Used by every module of the block; no dependencies.
package hnm_pkg;
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam int DIST_W = 9;
	localparam int CONF_W = 17;
	localparam int CNT_W  = 16;
endpackage

### rtl/hnm_cell.sv
// One distance cell: popcount of the XOR of one 64-bit descriptor word,
// summed with the partial distance handed in by its left neighbor.
// Depends on hnm_pkg.
module hnm_cell
	import hnm_pkg::*;
(
	input  logic              clk,
	input  logic [63:0]       query_word,
	input  logic [63:0]       ref_word,
	input  logic [63:0]       word_mask,
	input  logic [DIST_W-1:0] sum_in,
	output logic [DIST_W-1:0] sum_out
);
	logic [6:0] pop;
	always_comb begin
		pop = '0;
		for (int i = 0; i < 64; i++) begin
			pop = pop + 7'((query_word[i] ^ ref_word[i]) & word_mask[i]);
		end
	end
	always_ff @(posedge clk) begin
		sum_out <= sum_in + DIST_W'(pop);
	end
endmodule

### rtl/hnm_div.sv
// Restoring divider for the confidence value: floor((diff << 16) / divisor).
// One quotient bit per cycle. Depends on hnm_pkg.
module hnm_div
	import hnm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIST_W-1:0] diff,
	input  logic [DIST_W-1:0] divisor,
	output logic              done,
	output logic [CONF_W-1:0] quot
);
	logic [DIST_W+16:0] num_q;
	logic [DIST_W:0]    rem_q;
	logic [DIST_W-1:0]  dvs_q;
	logic [4:0]         cnt_q;
	logic               busy_q;
	logic [DIST_W+1:0]  trial;
	logic [DIST_W+1:0]  shifted;

	assign shifted = {rem_q, num_q[DIST_W+16]};
	assign trial   = shifted - {2'b0, dvs_q};
	assign quot    = num_q[CONF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIST_W + 16)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {1'b0, diff, 16'b0};
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIST_W+1]) begin
				rem_q <= trial[DIST_W:0];
				num_q <= {num_q[DIST_W+15:0], 1'b1};
			end else begin
				rem_q <= shifted[DIST_W:0];
				num_q <= {num_q[DIST_W+15:0], 1'b0};
			end
		end
	end
endmodule

### rtl/hamming_nearest_match_ratio_test.sv
// Brute-force Hamming matcher with ratio test over a stored reference table.
// Load and clear items are handled in the idle state. A query scans the table,
// one reference a cycle through a four-cell distance chain (set by the single
// table read port), then drains the chain and runs the bit-serial confidence
// divider on a passing match. One item at a time. arst_n clears the counters and
// sets the distance limit to 64; the table is undefined until loaded. Uses hnm_pkg.
module hamming_nearest_match_ratio_test
	import hnm_pkg::*;
#(
	parameter int MAX_REFS  = 1024,
	parameter int DESC_BITS = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [8:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// desc_word0, desc_word1, desc_word2, desc_word3 from bit 0 up
	input  logic [255:0] s_tdata,
	input  logic [1:0]   s_tuser,    // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	// query_index, ref_index, distance, confidence, match_count from bit 0 up
	output logic [71:0]  m_tdata
);
	localparam int AW = $clog2(MAX_REFS);
	localparam int CW = $clog2(MAX_REFS + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [255:0] ref_mem [MAX_REFS];
	logic [255:0] rd_s1;
	logic [63:0]  w1_s2, w2_s2, w2_s3, w3_s2, w3_s3, w3_s4;
	logic [63:0]  ref_skew [4];
	logic [255:0] qry_q;
	logic [255:0] mask;
	logic [2:0]   state_q;
	logic [8:0]   maxd_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] addr_q;
	logic [15:0]  qidx_q, mcnt_q, qcur_q;
	logic         v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [AW-1:0] i_s1, i_s2, i_s3, i_s4, i_s5;
	logic [DIST_W-1:0] sum [5];
	logic [DIST_W-1:0] best_q, second_q;
	logic [AW-1:0] bidx_q;
	logic         hb_q, hs_q;
	logic         div_start, div_done;
	logic [CONF_W-1:0] quot;
	logic [CONF_W-1:0] conf_q;
	logic         accept;
	logic         pass;

	always_comb begin
		for (int b = 0; b < 256; b++) mask[b] = (b < DESC_BITS);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {4'b0, mcnt_q, conf_q, best_q, 10'(bidx_q), qcur_q};
	assign sum[0]   = '0;

	always_ff @(posedge clk) begin
		if (accept && s_tuser == CMD_LOAD && cnt_q < CW'(MAX_REFS))
			ref_mem[cnt_q[AW-1:0]] <= s_tdata & mask;
		rd_s1 <= ref_mem[addr_q[AW-1:0]];
		if (accept) qry_q <= s_tdata & mask;
		i_s1 <= addr_q[AW-1:0];
		i_s2 <= i_s1; i_s3 <= i_s2; i_s4 <= i_s3; i_s5 <= i_s4;
		// Each upper word is delayed to meet the partial sum of its own reference.
		w1_s2 <= rd_s1[127:64];
		w2_s2 <= rd_s1[191:128]; w2_s3 <= w2_s2;
		w3_s2 <= rd_s1[255:192]; w3_s3 <= w3_s2; w3_s4 <= w3_s3;
	end

	assign ref_skew[0] = rd_s1[63:0];
	assign ref_skew[1] = w1_s2;
	assign ref_skew[2] = w2_s3;
	assign ref_skew[3] = w3_s4;

	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_cell
			hnm_cell u_cell (
				.clk        (clk),
				.query_word (qry_q[64*g +: 64]),
				.ref_word   (ref_skew[g]),
				.word_mask  (mask[64*g +: 64]),
				.sum_in     (sum[g]),
				.sum_out    (sum[g+1])
			);
		end
	endgenerate

	assign pass = hb_q && (best_q < maxd_q)
		&& (!hs_q || (12'(best_q) * 12'd5 < 12'(second_q) * 12'd4));
	assign div_start = (state_q == ST_DRAIN) && !v_s1 && !v_s2 && !v_s3 && !v_s4
		&& !v_s5 && pass;

	hnm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.diff    (maxd_q - best_q),
		.divisor (maxd_q),
		.done    (div_done),
		.quot    (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			maxd_q  <= 9'd64;
			cnt_q   <= '0;
			addr_q  <= '0;
			qidx_q  <= '0;
			mcnt_q  <= '0;
			qcur_q  <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			hb_q <= 1'b0; hs_q <= 1'b0;
			best_q <= '0; second_q <= '0; bidx_q <= '0; conf_q <= '0;
		end else begin
			if (cfg_we) maxd_q <= cfg_wdata;
			v_s1 <= (state_q == ST_SCAN) && (addr_q < cnt_q);
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			if (v_s5) begin
				if (!hb_q || sum[4] < best_q) begin
					if (hb_q) begin
						second_q <= best_q;
						hs_q     <= 1'b1;
					end
					best_q <= sum[4];
					bidx_q <= i_s5;
					hb_q   <= 1'b1;
				end else if (!hs_q || sum[4] < second_q) begin
					second_q <= sum[4];
					hs_q     <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							CMD_CLEAR: begin
								cnt_q  <= '0;
								qidx_q <= '0;
								mcnt_q <= '0;
							end
							CMD_LOAD: begin
								if (cnt_q < CW'(MAX_REFS)) cnt_q <= cnt_q + CW'(1);
							end
							CMD_QUERY: begin
								qcur_q  <= qidx_q;
								qidx_q  <= qidx_q + 16'd1;
								addr_q  <= '0;
								hb_q    <= 1'b0;
								hs_q    <= 1'b0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (addr_q < cnt_q) addr_q <= addr_q + CW'(1);
					else state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3 && !v_s4 && !v_s5)
						state_q <= pass ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_done) begin
						conf_q  <= quot;
						mcnt_q  <= mcnt_q + 16'd1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/hnm_checker.sv
// Port-level checker for the Hamming matcher, bound to the top level.
// Depends on hnm_pkg for the field widths.
module hnm_checker
	import hnm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed");
	a_conf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[51:35] <= 17'd65536) else $error("confidence range");
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[34:26] <= 9'd256)
		else $error("distance range");
endmodule

bind hamming_nearest_match_ratio_test hnm_checker u_hnm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
